// ----- src/dda_pkg.sv -----
// ----------------------------------------------------------------------------
// DDA line rasteriser package
// Shared widths, the item kind codes, the command word passed from the front
// end to the back end, and the pixel rounding function.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int CW    = 12;                 // coordinate bits
  localparam int FB    = 16;                 // fraction bits
  localparam int SW    = CW + 1;             // step count / delta magnitude bits
  localparam int PW    = CW + 1 + FB;        // position accumulator bits
  localparam int IW    = FB + 2;             // increment bits
  localparam int QW    = FB + 1;             // increment magnitude bits
  localparam int DCW   = $clog2(FB + 1);     // divider iteration counter bits
  localparam int IDW   = ((4 * CW + 7) / 8) * 8;
  localparam int ODW   = ((2 * CW + 7) / 8) * 8;
  localparam int QDEPTH = 2;
  localparam int QAW   = $clog2(QDEPTH);

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_ADV  = 1'b1
  } kind_t;

  // Classified item: endpoints already ordered left to right
  typedef struct packed {
    kind_t                 kind;
    logic signed [CW-1:0]  sx;
    logic signed [CW-1:0]  sy;
    logic                  neg_x;
    logic                  neg_y;
    logic        [SW-1:0]  mag_x;
    logic        [SW-1:0]  mag_y;
    logic        [SW-1:0]  steps;
  } cmd_t;

  // Round half away from zero: (p + half - sign) >>> FB
  function automatic logic signed [CW-1:0] round_pos(input logic signed [PW-1:0] p);
    logic [PW:0] half_v;
    logic [PW:0] sum;
    half_v         = '0;
    half_v[FB-1]   = 1'b1;
    sum = {p[PW-1], p} + half_v - {{PW{1'b0}}, p[PW-1]};
    return sum[FB+CW-1:FB];
  endfunction

endpackage

// ----- src/dda_queue.sv -----
// ----------------------------------------------------------------------------
// DDA command queue
// Short first-in first-out buffer of classified commands between the front
// and back ends.
// ----------------------------------------------------------------------------
module dda_queue
  import dda_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic valid,
  output cmd_t cmd,
  input  logic pop
);

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign valid = (count != '0);
  assign cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_cmd;
        wr_ptr          <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/dda_front.sv -----
// ----------------------------------------------------------------------------
// DDA front end
// Accepts input beats, orders the endpoints left to right, works out the
// deltas, their magnitudes and the step count, and pushes a command.
// ----------------------------------------------------------------------------
module dda_front
  import dda_pkg::*;
(
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [IDW-1:0] s_tdata,
  input  logic           s_tuser,
  input  logic           q_full,
  output logic           q_push,
  output cmd_t           q_cmd
);

  logic signed [CW-1:0] in_sx, in_sy, in_ex, in_ey;
  logic signed [CW-1:0] ax, ay, bx, by;
  logic signed [SW-1:0] dx, dy;
  logic        [SW-1:0] mx, my;
  logic                 swap;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    in_sx = s_tdata[CW-1:0];
    in_sy = s_tdata[2*CW-1:CW];
    in_ex = s_tdata[3*CW-1:2*CW];
    in_ey = s_tdata[4*CW-1:3*CW];

    swap = (in_sx > in_ex);
    ax   = swap ? in_ex : in_sx;
    ay   = swap ? in_ey : in_sy;
    bx   = swap ? in_sx : in_ex;
    by   = swap ? in_sy : in_ey;

    dx = {bx[CW-1], bx} - {ax[CW-1], ax};
    dy = {by[CW-1], by} - {ay[CW-1], ay};
    mx = dx[SW-1] ? SW'(-dx) : SW'(dx);
    my = dy[SW-1] ? SW'(-dy) : SW'(dy);

    q_cmd.kind  = kind_t'(s_tuser);
    q_cmd.sx    = ax;
    q_cmd.sy    = ay;
    q_cmd.neg_x = dx[SW-1];
    q_cmd.neg_y = dy[SW-1];
    q_cmd.mag_x = mx;
    q_cmd.mag_y = my;
    q_cmd.steps = (mx > my) ? mx : my;
  end

endmodule

// ----- src/dda_back.sv -----
// ----------------------------------------------------------------------------
// DDA back end
// Executes commands: runs the shift-subtract divider for the increments on a
// load, steps the fixed-point position on an advance, and holds the output
// register.
// ----------------------------------------------------------------------------
module dda_back
  import dda_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  cmd_t           q_cmd,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [ODW-1:0] m_tdata,
  output logic           m_tlast
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_START
  } state_t;

  state_t                state;
  logic                  active;
  logic signed [PW-1:0]  pos_x, pos_y;
  logic signed [IW-1:0]  incr_x, incr_y;
  logic        [SW-1:0]  steps_left;
  logic                  neg_x, neg_y;
  logic        [SW-1:0]  rem_x, rem_y;
  logic        [QW-1:0]  quo_x, quo_y;
  logic        [DCW-1:0] div_cnt;
  logic signed [CW-1:0]  point_x, point_y;

  logic                  out_free;
  logic                  out_load;
  logic signed [PW-1:0]  pos_x_next, pos_y_next;
  logic        [SW:0]    trial_x, trial_y;
  logic                  ge_x, ge_y;
  logic        [SW:0]    diff_x, diff_y;

  assign m_tdata  = {{(ODW-2*CW){1'b0}}, point_y, point_x};
  assign out_free = !m_tvalid || m_tready;

  // out_load: a new beat enters the output register this cycle
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    if (state == ST_RUN && q_valid) begin
      if (q_cmd.kind == KIND_LOAD) begin
        q_pop    = (q_cmd.steps != '0) || out_free;
        out_load = (q_cmd.steps == '0) && out_free;
      end else begin
        q_pop    = !active || out_free;
        out_load = active && out_free;
      end
    end else if (state == ST_START) begin
      out_load = out_free;
    end
  end

  always_comb begin
    pos_x_next = pos_x + {{(PW-IW){incr_x[IW-1]}}, incr_x};
    pos_y_next = pos_y + {{(PW-IW){incr_y[IW-1]}}, incr_y};
    // first iteration yields the integer bit, so no doubling
    trial_x = (div_cnt == '0) ? {1'b0, rem_x} : {rem_x, 1'b0};
    trial_y = (div_cnt == '0) ? {1'b0, rem_y} : {rem_y, 1'b0};
    ge_x    = (trial_x >= {1'b0, steps_left});
    ge_y    = (trial_y >= {1'b0, steps_left});
    diff_x  = trial_x - {1'b0, steps_left};
    diff_y  = trial_y - {1'b0, steps_left};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RUN;
      active   <= 1'b0;
      m_tvalid <= 1'b0;
      div_cnt  <= '0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_RUN: begin
          if (q_pop) begin
            if (q_cmd.kind == KIND_LOAD) begin
              pos_x      <= {q_cmd.sx[CW-1], q_cmd.sx, {FB{1'b0}}};
              pos_y      <= {q_cmd.sy[CW-1], q_cmd.sy, {FB{1'b0}}};
              steps_left <= q_cmd.steps;
              neg_x      <= q_cmd.neg_x;
              neg_y      <= q_cmd.neg_y;
              rem_x      <= q_cmd.mag_x;
              rem_y      <= q_cmd.mag_y;
              div_cnt    <= '0;
              active     <= 1'b0;
              if (q_cmd.steps == '0) begin
                // zero-length line: one point, marked last
                incr_x   <= '0;
                incr_y   <= '0;
                point_x  <= q_cmd.sx;
                point_y  <= q_cmd.sy;
                m_tlast  <= 1'b1;
                m_tvalid <= 1'b1;
              end else begin
                state <= ST_DIV;
              end
            end else if (active) begin
              pos_x      <= pos_x_next;
              pos_y      <= pos_y_next;
              steps_left <= steps_left - 1'b1;
              point_x    <= round_pos(pos_x_next);
              point_y    <= round_pos(pos_y_next);
              m_tlast    <= (steps_left == SW'(1));
              m_tvalid   <= 1'b1;
              active     <= (steps_left != SW'(1));
            end
          end
        end
        ST_DIV: begin
          rem_x   <= ge_x ? diff_x[SW-1:0] : trial_x[SW-1:0];
          rem_y   <= ge_y ? diff_y[SW-1:0] : trial_y[SW-1:0];
          quo_x   <= {quo_x[QW-2:0], ge_x};
          quo_y   <= {quo_y[QW-2:0], ge_y};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCW'(FB)) begin
            state <= ST_START;
          end
        end
        ST_START: begin
          incr_x <= neg_x ? -{1'b0, quo_x} : {1'b0, quo_x};
          incr_y <= neg_y ? -{1'b0, quo_y} : {1'b0, quo_y};
          if (out_free) begin
            point_x  <= pos_x[FB+CW-1:FB];
            point_y  <= pos_y[FB+CW-1:FB];
            m_tlast  <= 1'b0;
            m_tvalid <= 1'b1;
            active   <= 1'b1;
            state    <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule

// ----- src/dda_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// DDA line rasteriser
// Loads a pair of endpoints and walks the line one pixel per advance beat.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser is the kind (0 load endpoints, 1 advance). A load
// beat carries both endpoints in tdata; an advance beat ignores tdata.
// Output stream m_*: one pixel per beat, tlast marks the final pixel.
// A load emits the left endpoint first. For a line of non-zero length the
// increments come from a shift-subtract divider that retires one quotient bit
// per cycle; the start pixel follows once the divider is done, and a
// zero-length line gives its single pixel, marked last.
// Each advance beat yields the next pixel through the position adders, and
// advances sustain one beat per cycle while the output is not stalled.
// An advance with no line in progress gives no beat. A load during a line
// drops the rest of that line.
// A two-entry command queue parts input from execution, so input beats are
// still taken while the output is stalled, until the queue fills; a stalled
// output beat holds its value. Reset empties the queue and the output
// register and leaves the block idle.
// ----------------------------------------------------------------------------
module dda_line_rasterizer
  import dda_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [IDW-1:0] s_tdata,   // start_x, start_y, end_x, end_y
  input  logic           s_tuser,   // kind
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [ODW-1:0] m_tdata,   // point_x, point_y
  output logic           m_tlast
);

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_valid;
  cmd_t q_out;
  logic q_pop;

  dda_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  dda_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .valid    (q_valid),
    .cmd      (q_out),
    .pop      (q_pop)
  );

  dda_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- tb/dda_line_rasterizer_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasteriser checker
// Watches both streams of the rasteriser. Every load or advance beat taken
// on the input runs a local line walker that yields the pixel the block
// should produce. Every output beat is compared with the oldest pixel still
// due. The mismatch count and the number of pixels still due go to the top.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_chk
  import dda_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tready,
  input  logic [IDW-1:0] s_tdata,   // start_x, start_y, end_x, end_y
  input  logic           s_tuser,   // kind
  input  logic           m_tvalid,
  input  logic           m_tready,
  input  logic [ODW-1:0] m_tdata,   // point_x, point_y
  input  logic           m_tlast,
  output int             errors,
  output int             pending
);

  localparam longint UNIT = longint'(1) <<< FB;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 last_point;
  } pixel_t;

  // line walker state
  logic signed [PW-1:0] pos_x;
  logic signed [PW-1:0] pos_y;
  logic signed [IW-1:0] incr_x;
  logic signed [IW-1:0] incr_y;
  logic        [SW-1:0] steps_left;
  logic                 line_active;

  pixel_t pixels_due[$];
  int     fails;
  int     pixels_seen;

  // Nearest pixel, halves away from zero
  function automatic logic signed [CW-1:0] nearest_pixel(input logic signed [PW-1:0] p);
    longint v;
    longint half;
    longint q;
    v    = p;
    half = UNIT >>> 1;
    if (v >= 0) q = (v + half) >>> FB;
    else q = -((half - v) >>> FB);
    return q[CW-1:0];
  endfunction

  task automatic start_line(input logic [IDW-1:0] d);
    longint ax, ay, bx, by, t, dx, dy, mx, my, n;
    pixel_t pix;
    ax = $signed(d[CW-1:0]);
    ay = $signed(d[2*CW-1:CW]);
    bx = $signed(d[3*CW-1:2*CW]);
    by = $signed(d[4*CW-1:3*CW]);
    // walk always runs left to right
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx = bx - ax;
    dy = by - ay;
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    n  = (mx > my) ? mx : my;
    pos_x = PW'(ax * UNIT);
    pos_y = PW'(ay * UNIT);
    if (n != 0) begin
      incr_x = IW'((dx * UNIT) / n);
      incr_y = IW'((dy * UNIT) / n);
    end else begin
      incr_x = '0;
      incr_y = '0;
    end
    steps_left     = SW'(n);
    line_active    = (n != 0);
    pix.px         = ax[CW-1:0];
    pix.py         = ay[CW-1:0];
    pix.last_point = (n == 0);
    pixels_due.push_back(pix);
  endtask

  task automatic step_line();
    pixel_t pix;
    if (!line_active) return;
    pos_x      = pos_x + incr_x;
    pos_y      = pos_y + incr_y;
    steps_left = steps_left - 1'b1;
    if (steps_left == '0) line_active = 1'b0;
    pix.px         = nearest_pixel(pos_x);
    pix.py         = nearest_pixel(pos_y);
    pix.last_point = !line_active;
    pixels_due.push_back(pix);
  endtask

  task automatic check_pixel();
    pixel_t want;
    pixel_t got;
    got.px         = m_tdata[CW-1:0];
    got.py         = m_tdata[2*CW-1:CW];
    got.last_point = m_tlast;
    if (pixels_due.size() == 0) begin
      if (fails < 10)
        $display("pixel %0d: unexpected beat x=%0d y=%0d last=%0b",
                 pixels_seen, got.px, got.py, got.last_point);
      fails++;
    end else begin
      want = pixels_due.pop_front();
      if (got != want) begin
        if (fails < 10)
          $display("pixel %0d: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   pixels_seen, want.px, want.py, want.last_point,
                   got.px, got.py, got.last_point);
        fails++;
      end
    end
    pixels_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pos_x       = '0;
      pos_y       = '0;
      incr_x      = '0;
      incr_y      = '0;
      steps_left  = '0;
      line_active = 1'b0;
      pixels_due.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser == KIND_LOAD) start_line(s_tdata);
        else step_line();
      end
      if (m_tvalid && m_tready) check_pixel();
    end
    errors  <= fails;
    pending <= pixels_due.size();
  end

endmodule

// ----- tb/dda_line_rasterizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasteriser testbench
// Drives load and advance beats into the rasteriser: a directed set of edge
// lines first, then random lines walked to the end or cut short, with stray
// advances while idle. Both stream sides idle at random, and the output is
// held off twice for a long stretch. The checker compares every pixel.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_tb;
  import dda_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LINE_ITEMS   = 1720;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 64;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [IDW-1:0] s_tdata = '0;
  logic           s_tuser = 1'b0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [ODW-1:0] m_tdata;
  logic           m_tlast;

  int   errors;
  int   pending;
  int   work_items = 0;
  int   cycles = 0;
  int   rx_wait = 0;
  logic rx_hold = 1'b0;
  logic rx_burst = 1'b0;
  logic tx_burst = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dda_line_rasterizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  dda_line_rasterizer_chk u_chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: random stall after each beat, dropped during a hold
  always @(posedge clk) begin : rx_side
    int stall;
    stall = 0;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if ($urandom_range(0, 31) == 0) rx_burst <= !rx_burst;
        stall = rx_burst ? 0 : int'($urandom_range(0, 15));
      end else if (rx_wait != 0) begin
        stall = rx_wait - 1;
      end
      rx_wait  <= stall;
      m_tready <= (stall == 0) && !rx_hold;
    end
  end

  // Long output hold-offs, so that the command queue fills and stalls input
  initial begin
    wait (work_items >= 400);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
    wait (work_items >= 1100);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic logic [IDW-1:0] noise_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[IDW-1:0];
  endfunction

  function automatic int clamp_coord(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  task automatic offer_beat(input kind_t kind, input logic [IDW-1:0] data);
    int gap;
    gap = tx_burst ? 0 : int'($urandom_range(0, 15));
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic load_line(input int ax, input int ay, input int bx, input int by);
    offer_beat(KIND_LOAD, {by[CW-1:0], bx[CW-1:0], ay[CW-1:0], ax[CW-1:0]});
    work_items++;
  endtask

  task automatic advance(input int count);
    repeat (count) begin
      offer_beat(KIND_ADV, noise_word());
      work_items++;
    end
  endtask

  initial begin
    int ax, ay, bx, by, mx, my, n, walk, span, r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // advance with no line loaded
    offer_beat(KIND_ADV, noise_word());
    // zero-length line, then idle again
    load_line(5, -7, 5, -7);
    offer_beat(KIND_ADV, noise_word());
    // full-range diagonal given right to left, dropped by the next load
    load_line(2047, -2048, -2048, 2047);
    advance(3);
    // half-pixel steps, rounding up and down
    load_line(0, 0, 2, 1);
    advance(2);
    load_line(0, 0, 2, -1);
    advance(2);
    // vertical, cut short
    load_line(-3, 4, -3, -2);
    advance(2);
    load_line(-2048, -2048, -2048, -2048);
    load_line(2047, 2047, 2047, 2047);
    // steep line near the corner, walked to its end
    load_line(2045, -2048, 2047, -2044);
    advance(4);

    while (work_items < LINE_ITEMS) begin
      tx_burst = ($urandom_range(0, 5) == 0);
      r    = $urandom_range(0, 99);
      span = (r < 70) ? 8 : (r < 95) ? 64 : 4095;
      ax   = int'($urandom_range(0, 4095)) - 2048;
      ay   = int'($urandom_range(0, 4095)) - 2048;
      bx   = clamp_coord(ax + int'($urandom_range(0, 2 * span)) - span);
      by   = clamp_coord(ay + int'($urandom_range(0, 2 * span)) - span);
      mx   = (bx > ax) ? bx - ax : ax - bx;
      my   = (by > ay) ? by - ay : ay - by;
      n    = (mx > my) ? mx : my;
      walk = n;
      if (span == 4095) begin
        if (n > 40) walk = $urandom_range(0, 40);
      end else if ($urandom_range(0, 9) == 0) begin
        walk = $urandom_range(0, n);
      end
      load_line(ax, ay, bx, by);
      advance(walk);
      // stray advances once the line is done
      if (walk == n && $urandom_range(0, 6) == 0)
        repeat ($urandom_range(1, 3)) offer_beat(KIND_ADV, noise_word());
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- dda_line_rasterizer.f -----
src/dda_pkg.sv
src/dda_queue.sv
src/dda_front.sv
src/dda_back.sv
src/dda_line_rasterizer.sv
tb/dda_line_rasterizer_chk.sv
tb/dda_line_rasterizer_tb.sv
